// ===== sv/hte_pkg.sv =====
package hte_pkg;

  // Fixed field widths
  localparam int BYTE_W  = 8;
  localparam int CODE_W  = 32;
  localparam int LEN_W   = 6;
  localparam int TOTAL_W = 32;
  localparam int SYM_W   = 8;
  localparam int OP_W    = 2;
  localparam int REM_W   = 6;   // remaining code bits, 0..32
  localparam int PEND_W  = 3;   // bits waiting in the accumulator, 0..7
  localparam int STEP_W  = 4;   // bits taken in one packer step, 0..8

  // Stream widths
  localparam int IN_DATA_W  = 48;  // symbol, code_bits, code_length, pad
  localparam int OUT_DATA_W = 40;  // data_byte, total_bits

  // Defaults for the top level parameters
  localparam int DEF_MAX_CODE_LEN = 32;
  localparam int DEF_SYMBOL_COUNT = 256;

  // Operation codes on in_tuser
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

  // Result kinds on out_tuser
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic load_wr;     // write code and length tables from the input transfer
    logic enc_rd;      // read both tables at the input symbol
    logic fetch;       // left-align the read code into the shifter
    logic step;        // move one chunk of code bits into the accumulator
    logic flush_byte;  // emit the padded partial byte
    logic flush_end;   // emit the end record and clear the packer
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sym_ok;      // input symbol lies inside the table
    logic rem_zero;    // no code bits left in the shifter
    logic pend_zero;   // accumulator empty
    logic out_free;    // output register can take a result this cycle
  } sts_t;

endpackage

// ===== sv/hte_ctrl.sv =====
module hte_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic [hte_pkg::OP_W-1:0]   in_op,
  input  hte_pkg::sts_t              sts,
  output logic                       in_tready,
  output hte_pkg::cmd_t              cmd
);

  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_FETCH      = 3'd1;
  localparam logic [2:0] S_SHIFT      = 3'd2;
  localparam logic [2:0] S_FLUSH_DATA = 3'd3;
  localparam logic [2:0] S_FLUSH_END  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_op)
            hte_pkg::OP_LOAD: begin
              cmd.load_wr = sts.sym_ok;
            end
            hte_pkg::OP_ENCODE: begin
              if (sts.sym_ok) begin
                cmd.enc_rd = 1'b1;
                state_nxt  = S_FETCH;
              end
            end
            hte_pkg::OP_FLUSH: begin
              state_nxt = S_FLUSH_DATA;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        if (sts.rem_zero) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.step = 1'b1;
        end
      end
      S_FLUSH_DATA: begin
        if (sts.pend_zero) begin
          state_nxt = S_FLUSH_END;
        end else if (sts.out_free) begin
          cmd.flush_byte = 1'b1;
          state_nxt      = S_FLUSH_END;
        end
      end
      S_FLUSH_END: begin
        if (sts.out_free) begin
          cmd.flush_end = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Checks
  a_step_in_shift: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (state_r == S_SHIFT) && !sts.rem_zero)
    else $error("packer step outside the shift phase");

  a_fetch_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.enc_rd |=> cmd.fetch)
    else $error("table read not followed by fetch");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step || cmd.fetch || cmd.flush_byte || cmd.flush_end) |-> !in_tready)
    else $error("input ready while an item is in progress");

endmodule

// ===== sv/hte_dp.sv =====
module hte_dp #(
  parameter int MAX_CODE_LEN = hte_pkg::DEF_MAX_CODE_LEN,
  parameter int SYMBOL_COUNT = hte_pkg::DEF_SYMBOL_COUNT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [hte_pkg::SYM_W-1:0]         in_symbol,
  input  logic [hte_pkg::CODE_W-1:0]        in_code_bits,
  input  logic [hte_pkg::LEN_W-1:0]         in_code_length,
  input  hte_pkg::cmd_t                     cmd,
  output hte_pkg::sts_t                     sts,
  input  logic                              out_tready,
  output logic                              out_tvalid,
  output logic [hte_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tuser,
  output logic                              out_tlast
);

  localparam int IDX_W   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int LEN_LIM = (MAX_CODE_LEN < hte_pkg::CODE_W) ? MAX_CODE_LEN : hte_pkg::CODE_W;

  // Tables: code values undefined until loaded, lengths qualified by valid bits
  logic [hte_pkg::CODE_W-1:0] code_mem [SYMBOL_COUNT];
  logic [hte_pkg::LEN_W-1:0]  len_mem  [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0]    vld_r;

  logic [hte_pkg::CODE_W-1:0] code_rd_r;
  logic [hte_pkg::LEN_W-1:0]  len_rd_r;
  logic                       vld_rd_r;

  // Packer state
  logic [hte_pkg::CODE_W-1:0]  shift_r, shift_nxt;
  logic [hte_pkg::REM_W-1:0]   rem_r, rem_nxt;
  logic [hte_pkg::BYTE_W-1:0]  acc_r, acc_nxt;
  logic [hte_pkg::PEND_W-1:0]  pend_r, pend_nxt;
  logic [hte_pkg::TOTAL_W-1:0] total_r, total_nxt;

  // Output register
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_kind_r, out_kind_nxt;
  logic                        out_last_r, out_last_nxt;
  logic [hte_pkg::BYTE_W-1:0]  out_byte_r, out_byte_nxt;
  logic [hte_pkg::TOTAL_W-1:0] out_total_r, out_total_nxt;

  logic [IDX_W-1:0]           idx;
  logic [hte_pkg::LEN_W-1:0]  len_clamp;
  logic [hte_pkg::CODE_W:0]   len_one;
  logic [hte_pkg::CODE_W:0]   len_mask;
  logic [hte_pkg::LEN_W-1:0]  len_eff;
  logic [hte_pkg::STEP_W-1:0] room;
  logic [hte_pkg::STEP_W-1:0] take;
  logic [2*hte_pkg::BYTE_W-1:0] merged;
  logic [hte_pkg::STEP_W-1:0] pend_sum;
  logic [hte_pkg::REM_W-1:0]  rem_after;

  assign idx = in_symbol[IDX_W-1:0];

  // Load path: saturate the length and drop code bits above it
  assign len_clamp = (in_code_length > hte_pkg::LEN_W'(LEN_LIM))
                   ? hte_pkg::LEN_W'(LEN_LIM) : in_code_length;
  assign len_one   = (hte_pkg::CODE_W+1)'(1) << len_clamp;
  assign len_mask  = len_one - (hte_pkg::CODE_W+1)'(1);

  // Table write and registered read
  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      code_mem[idx] <= in_code_bits & len_mask[hte_pkg::CODE_W-1:0];
      len_mem[idx]  <= len_clamp;
    end
    if (cmd.enc_rd) begin
      code_rd_r <= code_mem[idx];
      len_rd_r  <= len_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      vld_rd_r <= 1'b0;
    end else begin
      if (cmd.load_wr) begin
        vld_r[idx] <= 1'b1;
      end
      if (cmd.enc_rd) begin
        vld_rd_r <= vld_r[idx];
      end
    end
  end

  assign len_eff = vld_rd_r ? len_rd_r : '0;

  // One packer step: take as many bits as fit in the accumulator
  assign room      = hte_pkg::STEP_W'(hte_pkg::BYTE_W) - {1'b0, pend_r};
  assign take      = (rem_r < hte_pkg::REM_W'(room)) ? rem_r[hte_pkg::STEP_W-1:0] : room;
  assign merged    = {acc_r, shift_r[hte_pkg::CODE_W-1 -: hte_pkg::BYTE_W]} << take;
  assign pend_sum  = {1'b0, pend_r} + take;
  assign rem_after = rem_r - hte_pkg::REM_W'(take);

  always_comb begin
    shift_nxt     = shift_r;
    rem_nxt       = rem_r;
    acc_nxt       = acc_r;
    pend_nxt      = pend_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = out_last_r;
    out_byte_nxt  = out_byte_r;
    out_total_nxt = out_total_r;

    if (cmd.fetch) begin
      shift_nxt = code_rd_r << (hte_pkg::LEN_W'(hte_pkg::CODE_W) - len_eff);
      rem_nxt   = len_eff;
      total_nxt = total_r + hte_pkg::TOTAL_W'(len_eff);
    end

    if (cmd.step) begin
      shift_nxt = shift_r << take;
      rem_nxt   = rem_after;
      if (pend_sum == hte_pkg::STEP_W'(hte_pkg::BYTE_W)) begin
        // byte complete: no further byte unless a whole one remains
        acc_nxt       = '0;
        pend_nxt      = '0;
        out_valid_nxt = 1'b1;
        out_kind_nxt  = hte_pkg::KIND_DATA;
        out_byte_nxt  = merged[2*hte_pkg::BYTE_W-1 -: hte_pkg::BYTE_W];
        out_total_nxt = '0;
        out_last_nxt  = (rem_after < hte_pkg::REM_W'(hte_pkg::BYTE_W));
      end else begin
        acc_nxt  = merged[2*hte_pkg::BYTE_W-1 -: hte_pkg::BYTE_W];
        pend_nxt = pend_sum[hte_pkg::PEND_W-1:0];
      end
    end

    if (cmd.flush_byte) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = hte_pkg::KIND_DATA;
      out_byte_nxt  = acc_r << room;
      out_total_nxt = '0;
      out_last_nxt  = 1'b0;
    end

    if (cmd.flush_end) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = hte_pkg::KIND_END;
      out_byte_nxt  = '0;
      out_total_nxt = total_r;
      out_last_nxt  = 1'b1;
      acc_nxt       = '0;
      pend_nxt      = '0;
      total_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= '0;
      acc_r       <= '0;
      pend_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rem_r       <= rem_nxt;
      acc_r       <= acc_nxt;
      pend_r      <= pend_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r     <= shift_nxt;
    out_kind_r  <= out_kind_nxt;
    out_last_r  <= out_last_nxt;
    out_byte_r  <= out_byte_nxt;
    out_total_r <= out_total_nxt;
  end

  // Status and result channel
  assign sts.sym_ok    = ({1'b0, in_symbol} < (hte_pkg::SYM_W+1)'(SYMBOL_COUNT));
  assign sts.rem_zero  = (rem_r == '0);
  assign sts.pend_zero = (pend_r == '0);
  assign sts.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_total_r, out_byte_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // Checks
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= hte_pkg::REM_W'(hte_pkg::CODE_W))
    else $error("remaining code bits exceed the code width");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step || cmd.flush_byte || cmd.flush_end) |-> sts.out_free)
    else $error("result written into a full output register");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush_end |=> (pend_r == '0) && (acc_r == '0) && (total_r == '0))
    else $error("packer not cleared after end record");

endmodule

// ===== sv/huffman_table_encoder.sv =====
// Channel  Dir  Handshake            Payload
// in_      in   in_tvalid/in_tready  tuser: op; tdata: symbol, code_bits, code_length
// out_     out  out_tvalid/out_tready tuser: kind; tlast: last; tdata: data_byte, total_bits
//
// Load writes the tables. Encode does a registered table read, fetches the code into
// the shifter, then runs at most 5 packer steps of up to one byte of code bits each.
// Flush emits any partial byte, then the end record. One item is in progress at a
// time; in_tready is high only between items. Reset clears the length table's valid
// bits. A stalled output register holds the packer until the result is taken.
module huffman_table_encoder #(
  parameter int MAX_CODE_LEN = hte_pkg::DEF_MAX_CODE_LEN,
  parameter int SYMBOL_COUNT = hte_pkg::DEF_SYMBOL_COUNT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [hte_pkg::IN_DATA_W-1:0]   in_tdata,   // symbol, code_bits, code_length, pad
  input  logic [hte_pkg::OP_W-1:0]        in_tuser,   // op
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [hte_pkg::OUT_DATA_W-1:0]  out_tdata,  // data_byte, total_bits
  output logic                            out_tuser,  // kind
  output logic                            out_tlast
);

  hte_pkg::cmd_t cmd;
  hte_pkg::sts_t sts;

  hte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser),
    .sts       (sts),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  hte_dp #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_symbol      (in_tdata[7:0]),
    .in_code_bits   (in_tdata[39:8]),
    .in_code_length (in_tdata[45:40]),
    .cmd            (cmd),
    .sts            (sts),
    .out_tready     (out_tready),
    .out_tvalid     (out_tvalid),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast)
  );

endmodule
